### hw/rtl/gemm_alpha_beta_unit_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef GEMM_ALPHA_BETA_UNIT_DEFINES_SVH
`define GEMM_ALPHA_BETA_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GAB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GAB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GAB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/gab_pkg.sv
package gab_pkg;

  localparam int MAX_ROWS  = 128;
  localparam int MAX_COLS  = 128;
  localparam int MAX_INNER = 64;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int INNER_W = $clog2(MAX_INNER);

  localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int B_DEPTH = MAX_INNER * MAX_COLS;
  localparam int C_DEPTH = MAX_ROWS * MAX_COLS;

  localparam int SUM_W = 38;
  localparam int RND_W = 26;
  localparam int SA_W  = 42;
  localparam int SC_W  = 48;
  localparam int TOT_W = 49;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_LOAD_C = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_ROWS  = 3'd0,
    REG_COLS  = 3'd1,
    REG_INNER = 3'd2,
    REG_ALPHA = 3'd3,
    REG_BETA  = 3'd4
  } reg_e;

  typedef struct packed {
    logic              a_we;
    logic              b_we;
    logic              c_we;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [31:0]       data;
  } gab_wr_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic zero;
  } gab_issue_t;

  typedef struct packed {
    logic        valid;
    logic        sat;
    logic [31:0] value;
  } gab_res_t;

endpackage

### hw/rtl/gab_store.sv
module gab_store (
  input  logic                       clk_i,
  input  gab_pkg::gab_wr_t           wr_i,
  input  logic                       rd_en_i,
  input  logic [gab_pkg::ROW_W-1:0]  rd_row_i,
  input  logic [gab_pkg::COL_W-1:0]  rd_col_i,
  input  logic [gab_pkg::INNER_W-1:0] rd_k_i,
  output logic [15:0]                a_rdata_o,
  output logic [15:0]                b_rdata_o,
  output logic [31:0]                c_rdata_o
);
  import gab_pkg::*;

  logic [15:0] a_mem [A_DEPTH];
  logic [15:0] b_mem [B_DEPTH];
  logic [31:0] c_mem [C_DEPTH];

  logic [ROW_W+INNER_W-1:0] a_waddr, a_raddr;
  logic [INNER_W+COL_W-1:0] b_waddr, b_raddr;
  logic [ROW_W+COL_W-1:0]   c_waddr, c_raddr;

  assign a_waddr = {wr_i.row, wr_i.col[INNER_W-1:0]};
  assign b_waddr = {wr_i.row[INNER_W-1:0], wr_i.col};
  assign c_waddr = {wr_i.row, wr_i.col};
  assign a_raddr = {rd_row_i, rd_k_i};
  assign b_raddr = {rd_k_i, rd_col_i};
  assign c_raddr = {rd_row_i, rd_col_i};

  always_ff @(posedge clk_i) begin
    if (wr_i.a_we) begin
      a_mem[a_waddr] <= wr_i.data[15:0];
    end
    if (rd_en_i) begin
      a_rdata_o <= a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.b_we) begin
      b_mem[b_waddr] <= wr_i.data[15:0];
    end
    if (rd_en_i) begin
      b_rdata_o <= b_mem[b_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.c_we) begin
      c_mem[c_waddr] <= wr_i.data;
    end
    if (rd_en_i) begin
      c_rdata_o <= c_mem[c_raddr];
    end
  end

endmodule

### hw/rtl/gab_mac.sv
module gab_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  gab_pkg::gab_issue_t issue_i,
  input  logic [15:0]         a_rdata_i,
  input  logic [15:0]         b_rdata_i,
  input  logic [31:0]         c_rdata_i,
  input  logic [15:0]         alpha_i,
  input  logic [15:0]         beta_i,
  input  logic                take_i,
  output gab_pkg::gab_res_t   res_o
);
  import gab_pkg::*;

  logic               rd_v_q, rd_last_q, rd_zero_q;
  logic               prod_v_q, prod_last_q;
  logic signed [31:0] prod_q;
  logic signed [SUM_W-1:0] acc_q;
  logic               sum_v_q;
  logic signed [SA_W-1:0] sa_q;
  logic signed [SC_W-1:0] sc_q;
  logic               scl_v_q;
  logic               res_valid_q;
  logic               res_sat_q;
  logic [31:0]        res_value_q;

  logic signed [31:0]      prod_d;
  logic signed [SUM_W-1:0] rnd_full;
  logic signed [RND_W-1:0] rnd;
  logic signed [TOT_W-1:0] total;
  logic signed [TOT_W-9:0] shifted;
  logic                    ovf_hi, ovf_lo;

  assign prod_d   = rd_zero_q ? 32'sd0 : $signed(a_rdata_i) * $signed(b_rdata_i);
  assign rnd_full = acc_q + SUM_W'(2048);
  assign rnd      = rnd_full[SUM_W-1:12];
  assign total    = TOT_W'(sa_q) + TOT_W'(sc_q);
  assign shifted  = total[TOT_W-1:8];
  assign ovf_hi   = !shifted[TOT_W-9] && (shifted[TOT_W-10:31] != '0);
  assign ovf_lo   = shifted[TOT_W-9] && (shifted[TOT_W-10:31] != '1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      rd_zero_q   <= 1'b0;
      prod_v_q    <= 1'b0;
      prod_last_q <= 1'b0;
      sum_v_q     <= 1'b0;
      scl_v_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      rd_v_q      <= issue_i.valid;
      rd_last_q   <= issue_i.valid && issue_i.last;
      rd_zero_q   <= issue_i.zero;
      prod_v_q    <= rd_v_q;
      prod_last_q <= rd_last_q;
      sum_v_q     <= prod_v_q && prod_last_q;
      scl_v_q     <= sum_v_q;
      if (scl_v_q) begin
        res_valid_q <= 1'b1;
      end else if (take_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (start_i) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end
    if (sum_v_q) begin
      sa_q <= $signed(alpha_i) * rnd;
      sc_q <= (beta_i != '0) ? $signed(beta_i) * $signed(c_rdata_i) : $signed(SC_W'(0));
    end
    if (scl_v_q) begin
      res_sat_q <= ovf_hi || ovf_lo;
      if (ovf_hi) begin
        res_value_q <= 32'h7fff_ffff;
      end else if (ovf_lo) begin
        res_value_q <= 32'h8000_0000;
      end else begin
        res_value_q <= shifted[31:0];
      end
    end
  end

  assign res_o = {res_valid_q, res_sat_q, res_value_q};

endmodule

### hw/rtl/gemm_alpha_beta_unit.sv
// Channel   Direction  tdata (low bit up)                 tuser
// s_axis    in         row_index, col_index, element_value op
// m_axis    out        d_value, d_row, d_col              status
// cfg       in         cfg_wdata_i at index cfg_idx_i     -
//
// A read in range issues K products, K being the clamped inner size (at
// least one issue slot), through the single multiply-accumulate that walks
// the A and B memories one product per cycle. An out-of-range read returns
// a range status without the multiply-accumulate. Reset restores the
// configuration and control registers, not the memories. A stalled result
// holds the output register and a finished read until it can move there.
`include "gemm_alpha_beta_unit_defines.svh"

module gemm_alpha_beta_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // row_index [6:0], col_index [13:7], element_value [45:14], zero fill
  input  logic [47:0] s_axis_tdata,
  // op [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // d_value [31:0], d_row [38:32], d_col [45:39], zero fill
  output logic [47:0] m_axis_tdata,
  // status [1:0]
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import gab_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_ORNG
  } state_e;

  state_e state_q;
  logic [7:0]  rows_q, cols_q;
  logic [6:0]  inner_q;
  logic [15:0] alpha_q, beta_q;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic [INNER_W-1:0] k_q;
  logic [INNER_W:0]   klim_q;
  logic        out_valid_q;
  logic [31:0] out_value_q;
  logic [ROW_W-1:0] out_row_q;
  logic [COL_W-1:0] out_col_q;
  status_e     out_status_q;

  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [31:0]      in_value;
  op_e              in_op;
  logic             in_acc, out_free, read_ok;
  logic             out_load;
  logic [7:0]       m_lim, n_lim;
  logic [INNER_W:0] k_lim;
  logic             row_m_ok, row_k_ok, col_n_ok, col_k_ok;
  gab_wr_t          wr;
  gab_issue_t       issue;
  gab_res_t         res;
  logic [15:0]      a_rdata, b_rdata;
  logic [31:0]      c_rdata;
  logic             take;

  assign in_row   = s_axis_tdata[ROW_W-1:0];
  assign in_col   = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
  assign in_value = s_axis_tdata[ROW_W+COL_W+31:ROW_W+COL_W];
  assign in_op    = op_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_lim = (rows_q > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : rows_q;
  assign n_lim = (cols_q > 8'(MAX_COLS)) ? 8'(MAX_COLS) : cols_q;
  assign k_lim = (inner_q > 7'(MAX_INNER)) ? (INNER_W+1)'(MAX_INNER)
                                           : (INNER_W+1)'(inner_q);

  assign row_m_ok = {1'b0, in_row} < m_lim;
  assign col_n_ok = {1'b0, in_col} < n_lim;
  assign row_k_ok = (INNER_W+1)'(in_row) < k_lim && (in_row < 7'(MAX_INNER));
  assign col_k_ok = (INNER_W+1)'(in_col) < k_lim && (in_col < 7'(MAX_INNER));
  assign read_ok  = row_m_ok && col_n_ok;

  always_comb begin
    wr      = '0;
    wr.row  = in_row;
    wr.col  = in_col;
    wr.data = in_value;
    if (in_acc) begin
      unique case (in_op)
        OP_LOAD_A: wr.a_we = row_m_ok && col_k_ok;
        OP_LOAD_B: wr.b_we = row_k_ok && col_n_ok;
        OP_LOAD_C: wr.c_we = row_m_ok && col_n_ok;
        OP_READ:   wr = wr;
        default:   wr = wr;
      endcase
    end
  end

  assign issue.valid = (state_q == S_RUN);
  assign issue.zero  = (klim_q == '0);
  assign issue.last  = issue.zero || (({1'b0, k_q} + 1'b1) == klim_q);
  assign take        = (state_q == S_WAIT) && res.valid && out_free;
  assign out_load    = take || ((state_q == S_ORNG) && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 8'(MAX_ROWS);
      cols_q  <= 8'(MAX_COLS);
      inner_q <= 7'(MAX_INNER);
      alpha_q <= 16'd256;
      beta_q  <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROWS:  rows_q  <= cfg_wdata_i[7:0];
        REG_COLS:  cols_q  <= cfg_wdata_i[7:0];
        REG_INNER: inner_q <= cfg_wdata_i[6:0];
        REG_ALPHA: alpha_q <= cfg_wdata_i;
        REG_BETA:  beta_q  <= cfg_wdata_i;
        default:   rows_q  <= rows_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && in_op == OP_READ) begin
            row_q  <= in_row;
            col_q  <= in_col;
            k_q    <= '0;
            klim_q <= k_lim;
            state_q <= read_ok ? S_RUN : S_ORNG;
          end
        end
        S_RUN: begin
          if (issue.last) begin
            state_q <= S_WAIT;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_WAIT: begin
          if (take) begin
            out_value_q  <= res.value;
            out_row_q    <= row_q;
            out_col_q    <= col_q;
            out_status_q <= res.sat ? ST_SAT : ST_OK;
            state_q      <= S_IDLE;
          end
        end
        S_ORNG: begin
          if (out_free) begin
            out_value_q  <= '0;
            out_row_q    <= row_q;
            out_col_q    <= col_q;
            out_status_q <= ST_RANGE;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  gab_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (issue.valid),
    .rd_row_i  (row_q),
    .rd_col_i  (col_q),
    .rd_k_i    (k_q),
    .a_rdata_o (a_rdata),
    .b_rdata_o (b_rdata),
    .c_rdata_o (c_rdata)
  );

  gab_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc && in_op == OP_READ),
    .issue_i   (issue),
    .a_rdata_i (a_rdata),
    .b_rdata_i (b_rdata),
    .c_rdata_i (c_rdata),
    .alpha_i   (alpha_q),
    .beta_i    (beta_q),
    .take_i    (take),
    .res_o     (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_col_q, out_row_q, out_value_q};
  assign m_axis_tuser  = out_status_q;

  `GAB_ASSERT_IMPL(a_res_only_waiting, clk_i, rst_ni, res.valid, state_q == S_WAIT)
  `GAB_ASSERT_NEXT(a_last_issue_waits, clk_i, rst_ni, issue.valid && issue.last,
                   state_q == S_WAIT)
  `GAB_ASSERT_IMPL(a_sat_clamped, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == ST_SAT,
                   m_axis_tdata[31:0] == 32'h7fff_ffff || m_axis_tdata[31:0] == 32'h8000_0000)

endmodule
